/* rtl/svc_pkg.sv */
// ----------------------------------------------------------------------------
// Signed varint codec package
// Shared types, codes and field positions for the signed LEB128 codec.
// ----------------------------------------------------------------------------
package svc_pkg;

   // Operation codes carried in the request tuser.
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // Stream widths: tdata is padded to whole bytes.
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   // Request tuser bit positions.
   localparam int REQ_USER_OP  = 0;
   localparam int REQ_USER_EOD = 1;

   // Response tuser bit positions.
   localparam int RSP_USER_BV  = 0;
   localparam int RSP_USER_VV  = 1;
   localparam int RSP_USER_ERR = 2;

   // Coding constants.
   localparam int GROUP_BITS = 7;
   localparam logic [5:0] SHIFT_MAX = 6'd63;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic enc_load;   // capture the value to encode
      logic enc_emit;   // emit one encoded byte into the output register
      logic dec_step;   // process one decode transaction
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;  // output register empty or being taken this cycle
      logic enc_final;  // remaining value fits in one final byte
   } stat_type;

endpackage

/* rtl/svc_ctrl.sv */
// ----------------------------------------------------------------------------
// Signed varint codec controller
// Sequences request acceptance and the byte-by-byte emission of an encode.
// ----------------------------------------------------------------------------
module svc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_op,
   input  svc_pkg::stat_type stat,
   output svc_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_ENC  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && stat.slot_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.enc_load = accept && (req_op == svc_pkg::OP_ENCODE);
      cmd.dec_step = accept && (req_op == svc_pkg::OP_DECODE);
      cmd.enc_emit = (state_ff == ST_ENC) && stat.slot_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.enc_load) begin
               state_in = ST_ENC;
            end
         end
         ST_ENC: begin
            if (cmd.enc_emit && stat.enc_final) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/svc_datapath.sv */
// ----------------------------------------------------------------------------
// Signed varint codec datapath
// Encode shift register, decode accumulator and the registered result stage.
// ----------------------------------------------------------------------------
module svc_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  svc_pkg::cmd_type                 cmd,
   output svc_pkg::stat_type                stat,
   input  logic [svc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [svc_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [svc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [svc_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int W = VALUE_WIDTH;

   // Request fields.
   logic signed [31:0] value;
   logic [7:0]         byte_in;
   logic               end_of_data;

   assign value       = req_tdata[31:0];
   assign byte_in     = req_tdata[39:32];
   assign end_of_data = req_tuser[svc_pkg::REQ_USER_EOD];

   // Encode value register, shifted right by one group per emitted byte.
   logic [W-1:0] x_ff, x_in;

   // Decode state.
   logic [W-1:0] psum_ff, psum_in;
   logic [5:0]   shift_ff, shift_in;

   // Output register.
   logic               ovalid_ff, ovalid_in;
   logic [7:0]         obyte_ff, obyte_in;
   logic               obv_ff, obv_in;
   logic               olast_ff, olast_in;
   logic signed [31:0] odv_ff, odv_in;
   logic               ovv_ff, ovv_in;
   logic               oerr_ff, oerr_in;

   logic         load_out;
   logic [W-1:0] group_ext;
   logic [W-1:0] addend;
   logic [W-1:0] sum;
   logic [6:0]   shift_next;
   logic         dec_cont;

   assign stat.slot_free = !ovalid_ff || rsp_tready;
   // Final byte when the upper bits are a pure sign extension of bit 6.
   assign stat.enc_final = (&x_ff[W-1:6]) || (~|x_ff[W-1:6]);

   assign dec_cont = byte_in[7];

   // Continuation groups are added unsigned, the terminating group signed.
   always_comb begin
      if (dec_cont) begin
         group_ext = W'(byte_in[6:0]);
      end else begin
         group_ext = W'($signed(byte_in[6:0]));
      end
      addend     = group_ext << shift_ff;
      sum        = psum_ff + addend;
      shift_next = {1'b0, shift_ff} + 7'(svc_pkg::GROUP_BITS);
   end

   always_comb begin
      x_in     = x_ff;
      psum_in  = psum_ff;
      shift_in = shift_ff;
      load_out = 1'b0;
      obyte_in = obyte_ff;
      obv_in   = obv_ff;
      olast_in = olast_ff;
      odv_in   = odv_ff;
      ovv_in   = ovv_ff;
      oerr_in  = oerr_ff;

      if (cmd.enc_load) begin
         x_in = W'(value);
      end

      if (cmd.enc_emit) begin
         load_out = 1'b1;
         obyte_in = {!stat.enc_final, x_ff[6:0]};
         obv_in   = 1'b1;
         olast_in = stat.enc_final;
         odv_in   = '0;
         ovv_in   = 1'b0;
         oerr_in  = 1'b0;
         x_in     = W'($signed(x_ff) >>> svc_pkg::GROUP_BITS);
      end

      if (cmd.dec_step) begin
         if (end_of_data) begin
            load_out = 1'b1;
            obyte_in = '0;
            obv_in   = 1'b0;
            olast_in = 1'b1;
            odv_in   = '0;
            ovv_in   = 1'b1;
            oerr_in  = 1'b1;
            psum_in  = '0;
            shift_in = '0;
         end else if (dec_cont) begin
            psum_in = sum;
            if (shift_next > 7'(svc_pkg::SHIFT_MAX)) begin
               shift_in = svc_pkg::SHIFT_MAX;
            end else begin
               shift_in = shift_next[5:0];
            end
         end else begin
            load_out = 1'b1;
            obyte_in = '0;
            obv_in   = 1'b0;
            olast_in = 1'b1;
            odv_in   = 32'($signed(sum));
            ovv_in   = 1'b1;
            oerr_in  = 1'b0;
            psum_in  = '0;
            shift_in = '0;
         end
      end

      if (load_out) begin
         ovalid_in = 1'b1;
      end else if (rsp_tready) begin
         ovalid_in = 1'b0;
      end else begin
         ovalid_in = ovalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
         psum_ff   <= '0;
         shift_ff  <= '0;
      end else begin
         ovalid_ff <= ovalid_in;
         psum_ff   <= psum_in;
         shift_ff  <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      obyte_ff <= obyte_in;
      obv_ff   <= obv_in;
      olast_ff <= olast_in;
      odv_ff   <= odv_in;
      ovv_ff   <= ovv_in;
      oerr_ff  <= oerr_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {odv_ff, obyte_ff};
   assign rsp_tuser  = {oerr_ff, ovv_ff, obv_ff};
   assign rsp_tlast  = olast_ff;

endmodule

/* rtl/signed_varint_codec_unit.sv */
// ----------------------------------------------------------------------------
// Signed varint codec unit
// Signed LEB128 encoder and byte-wise decoder behind stream interfaces.
// ----------------------------------------------------------------------------
// Each request transaction is either an encode (a 32-bit signed value) or a
// decode step (one coded byte, or an end-of-data marker). Encode requests
// produce one response transaction per coded byte, least significant group
// first, with tlast on the final byte. A decode continuation byte produces no
// response; a terminating byte produces the decoded value, and an end-of-data
// marker produces an error response with a zero value.
// Results leave through a single output register. A decode response appears
// in the cycle after its request is accepted, and a decode request can be taken
// every cycle while no encode is under way and the output keeps draining. An
// encode holds the request side while it loads the value and then emits its
// bytes one at a time from the shift-right-by-seven register. When the
// receiver stalls, the output register holds its transaction and the request
// side waits until the register can be refilled. Reset empties the output
// register, returns the controller to idle and clears the decode accumulator
// and its group shift.
// ----------------------------------------------------------------------------
module signed_varint_codec_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], byte_in[39:32]
   input  logic [1:0]  req_tuser,   // operation[0], end_of_data[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // byte_out[7:0], decoded_value[39:8]
   output logic [2:0]  rsp_tuser,   // byte_valid[0], value_valid[1], error[2]
   output logic        rsp_tlast    // last
);

   svc_pkg::cmd_type  cmd;
   svc_pkg::stat_type stat;

   // The controller decides when a transaction is taken and when the next
   // encoded byte goes out; all payload work happens in the datapath.
   svc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[svc_pkg::REQ_USER_OP]),
      .stat       (stat),
      .cmd        (cmd)
   );

   svc_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // A stalled response leaves no room for a new request transaction.
   a_no_accept_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request ready while the output register is stalled");

   // An accepted encode occupies the unit for at least the next cycle.
   a_encode_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (req_tuser[svc_pkg::REQ_USER_OP] == svc_pkg::OP_ENCODE)) |=> !req_tready)
      else $error("request ready right after an encode was accepted");

   // Every response is either an encoded byte or a decode result.
   a_kind_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[svc_pkg::RSP_USER_BV] != rsp_tuser[svc_pkg::RSP_USER_VV]))
      else $error("response is neither or both of byte and value");

   // An error response is a final decode result with a zero value.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[svc_pkg::RSP_USER_ERR]) |->
      (rsp_tlast && rsp_tuser[svc_pkg::RSP_USER_VV] && (rsp_tdata[39:8] == 32'd0)))
      else $error("malformed error response");
`endif

endmodule

/* tb/signed_varint_codec_unit_tb.sv */
// ----------------------------------------------------------------------------
// Signed varint codec unit testbench
// Drives encode values and decode bytes into the codec over its request stream
// and checks every response transaction against a cycle-free predictor of
// signed LEB128 coding or an expected response typed into a directed row.
// A short directed table, then random traffic with random stalls on both streams.
// ----------------------------------------------------------------------------
module signed_varint_codec_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One response transaction, unpacked into its fields.
   typedef struct packed {
      logic [7:0]  byte_out;
      logic        byte_valid;
      logic        last;
      logic [31:0] decoded_value;
      logic        value_valid;
      logic        err;
   } codec_rsp_type;

   // One row of stimulus. When has_exp is set the expected response is
   // typed into the row instead of being taken from the predictor.
   typedef struct {
      logic          op;
      logic [31:0]   value;
      logic [7:0]    byte_in;
      logic          eod;
      bit            has_exp;
      codec_rsp_type exp;
   } stim_row_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 458;
   localparam int CALM_ITEMS     = 80;

   localparam codec_rsp_type DECODE_ERROR_RSP = '{
      byte_out: 8'h00, byte_valid: 1'b0, last: 1'b1,
      decoded_value: 32'h0, value_valid: 1'b1, err: 1'b1
   };

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [svc_pkg::REQ_DATA_W-1:0] req_tdata;   // value[31:0], byte_in[39:32]
   logic [svc_pkg::REQ_USER_W-1:0] req_tuser;   // operation[0], end_of_data[1]
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [svc_pkg::RSP_DATA_W-1:0] rsp_tdata;   // byte_out[7:0], decoded_value[39:8]
   logic [svc_pkg::RSP_USER_W-1:0] rsp_tuser;   // byte_valid[0], value_valid[1], error[2]
   logic                           rsp_tlast;

   signed_varint_codec_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Predictor state: the decode accumulator and its group shift.
   logic [31:0] acc_sum;
   logic [5:0]  acc_shift;

   // Responses produced by the latest accepted request.
   codec_rsp_type step_out [5];
   int            step_count;

   // Responses still owed by the codec, oldest first.
   codec_rsp_type leb_results_q [$];

   stim_row_type  directed_rows [$];

   bit          req_idle_on;
   bit          rsp_idle_on;

   int          n_requests;
   int          n_enc_bytes;
   int          n_dec_values;
   int          n_dec_errors;
   int          n_checked;
   int          n_fail;
   int          idle_cycles;

   // ------------------------------------------------------------------------
   // Clock.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Response builders.
   // ------------------------------------------------------------------------
   function automatic codec_rsp_type enc_byte(input logic [7:0] b, input logic is_last);
      codec_rsp_type r;
      r = '0;
      r.byte_out   = b;
      r.byte_valid = 1'b1;
      r.last       = is_last;
      return r;
   endfunction

   function automatic codec_rsp_type dec_done(input logic [31:0] v);
      codec_rsp_type r;
      r = '0;
      r.last          = 1'b1;
      r.decoded_value = v;
      r.value_valid   = 1'b1;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Signed LEB128 predictor. An encode emits one byte per 7-bit group until
   // the remainder fits in -64..63, then the final byte. A decode byte with
   // bit 7 set folds its group into the accumulator; a byte with bit 7 clear
   // adds its sign-extended group and completes the value. End of data
   // during decode reports an error. Encodes never touch the decode state.
   // ------------------------------------------------------------------------
   task automatic leb128_predict(input logic op, input logic [31:0] value,
                                 input logic [7:0] b, input logic eod);
      logic [31:0] rem;
      logic [63:0] grp;
      int          next_shift;
      int          n;
      n = 0;
      if (op == svc_pkg::OP_ENCODE) begin
         rem = value;
         while ($signed(rem) < -64 || $signed(rem) > 63) begin
            step_out[n] = enc_byte({1'b1, rem[6:0]}, 1'b0);
            n++;
            rem = $signed(rem) >>> svc_pkg::GROUP_BITS;
         end
         step_out[n] = enc_byte({1'b0, rem[6:0]}, 1'b1);
         n++;
      end else if (eod) begin
         step_out[0] = DECODE_ERROR_RSP;
         n = 1;
         acc_sum   = '0;
         acc_shift = '0;
      end else if (b[7]) begin
         // Continuation byte: no response. The shift saturates so that an
         // overlong stream keeps adding groups that fall off the top.
         grp = {57'd0, b[6:0]} << acc_shift;
         acc_sum = acc_sum + grp[31:0];
         next_shift = int'(acc_shift) + svc_pkg::GROUP_BITS;
         acc_shift = (next_shift > int'(svc_pkg::SHIFT_MAX)) ? svc_pkg::SHIFT_MAX
                                                             : next_shift[5:0];
      end else begin
         grp = {{57{b[6]}}, b[6:0]} << acc_shift;
         step_out[0] = dec_done(acc_sum + grp[31:0]);
         n = 1;
         acc_sum   = '0;
         acc_shift = '0;
      end
      step_count = n;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Inputs change at the falling edge; the transaction is
   // taken at the first rising edge with req_tready high. The task returns at
   // the falling edge after acceptance so the next row can follow directly.
   // ------------------------------------------------------------------------
   task automatic send_row(input stim_row_type row);
      logic [svc_pkg::REQ_USER_W-1:0] tu;
      int gap;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {8'($urandom), $urandom};
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
      end
      tu = '0;
      tu[svc_pkg::REQ_USER_OP]  = row.op;
      tu[svc_pkg::REQ_USER_EOD] = row.eod;
      req_tvalid <= 1'b1;
      req_tdata  <= {row.byte_in, row.value};
      req_tuser  <= tu;
      do @(posedge clock); while (!req_tready);

      // The transaction is accepted at this edge: advance the predictor and
      // queue what the codec now owes.
      n_requests++;
      leb128_predict(row.op, row.value, row.byte_in, row.eod);
      if (row.has_exp) begin
         leb_results_q.push_back(row.exp);
      end else begin
         for (int i = 0; i < step_count; i++) leb_results_q.push_back(step_out[i]);
      end
      for (int i = 0; i < step_count; i++) begin
         if (step_out[i].byte_valid) n_enc_bytes++;
         else if (step_out[i].err) n_dec_errors++;
         else n_dec_values++;
      end
      @(negedge clock);
   endtask

   task automatic add_row(input logic op, input logic [31:0] value, input logic [7:0] b,
                          input logic eod, input bit has_exp, input codec_rsp_type exp);
      stim_row_type row;
      row.op      = op;
      row.value   = value;
      row.byte_in = b;
      row.eod     = eod;
      row.has_exp = has_exp;
      row.exp     = exp;
      directed_rows.push_back(row);
   endtask

   // Random value to encode, spread over every coded length from one to five
   // bytes, with the extremes now and then.
   function automatic logic [31:0] rand_value();
      int          k;
      logic [31:0] r;
      k = $urandom_range(0, 5);
      r = $urandom;
      if (k == 5) begin
         case ($urandom_range(0, 3))
            0:       r = 32'h7FFF_FFFF;
            1:       r = 32'h8000_0000;
            2:       r = 32'h0000_0000;
            default: r = 32'hFFFF_FFFF;
         endcase
      end else if (k < 4) begin
         r = $signed(r) >>> (25 - svc_pkg::GROUP_BITS * k);
      end
      return r;
   endfunction

   task automatic send_random(input logic op, input logic [31:0] value,
                              input logic [7:0] b, input logic eod);
      stim_row_type row;
      row.op      = op;
      row.value   = value;
      row.byte_in = b;
      row.eod     = eod;
      row.has_exp = 1'b0;
      row.exp     = '0;
      req_idle_on = (n_requests < RANDOM_ITEMS - CALM_ITEMS);
      rsp_idle_on = req_idle_on;
      send_row(row);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   initial begin
      int          start_count;
      int          sel;
      int          n_cont;
      logic [7:0]  b;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      acc_sum     = '0;
      acc_shift   = '0;
      step_count  = 0;
      n_requests  = 0;
      n_enc_bytes = 0;
      n_dec_values = 0;
      n_dec_errors = 0;
      n_checked   = 0;
      n_fail      = 0;

      // Directed table. End of data straight after reset must report an
      // error; the single-byte decodes and encodes cover the edges of the
      // -64..63 range where one group is enough.
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'hAB, 1'b1, 1'b1, DECODE_ERROR_RSP);
      add_row(svc_pkg::OP_DECODE, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, dec_done(32'h0));
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'h7F, 1'b0, 1'b1,
              dec_done(32'hFFFF_FFFF));
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'h3F, 1'b0, 1'b1, dec_done(32'd63));
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'h40, 1'b0, 1'b1,
              dec_done(32'hFFFF_FFC0));
      add_row(svc_pkg::OP_ENCODE, 32'h0,         8'hFF, 1'b0, 1'b1, enc_byte(8'h00, 1'b1));
      // End of data on an encode is ignored.
      add_row(svc_pkg::OP_ENCODE, 32'd63,        8'h00, 1'b1, 1'b1, enc_byte(8'h3F, 1'b1));
      add_row(svc_pkg::OP_ENCODE, 32'hFFFF_FFC0, 8'h00, 1'b0, 1'b1, enc_byte(8'h40, 1'b1));
      add_row(svc_pkg::OP_ENCODE, 32'd64,        8'h00, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_ENCODE, 32'hFFFF_FFBF, 8'h00, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_ENCODE, 32'h7FFF_FFFF, 8'h00, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_ENCODE, 32'h8000_0000, 8'h00, 1'b0, 1'b0, '0);
      // Five-byte decode of the largest positive value.
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'hFF, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'hFF, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'hFF, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'hFF, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'h07, 1'b0, 1'b0, '0);
      // An encode in the middle of a decode leaves the accumulator alone.
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'h80, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_ENCODE, 32'd5,         8'h00, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'h01, 1'b0, 1'b0, '0);
      // A stream that ends after a continuation byte is an error, and the
      // accumulator starts over afterwards.
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'h85, 1'b0, 1'b0, '0);
      add_row(svc_pkg::OP_DECODE, 32'h0,         8'h00, 1'b1, 1'b1, DECODE_ERROR_RSP);

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_row(directed_rows[i]);

      // Random traffic. Most of it is well-formed decode sequences with
      // random groups, some overlong, some cut short by end of data, some
      // with an encode slipped in; the rest is encodes, lone end-of-data
      // markers and arbitrary bytes.
      start_count = n_requests;
      while (n_requests - start_count < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            send_random(svc_pkg::OP_ENCODE, rand_value(), 8'($urandom), 1'($urandom));
         end else if (sel < 80) begin
            n_cont = $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0) n_cont = $urandom_range(5, 11);
            for (int i = 0; i < n_cont; i++) begin
               b = 8'($urandom);
               send_random(svc_pkg::OP_DECODE, $urandom, {1'b1, b[6:0]}, 1'b0);
               if ($urandom_range(0, 11) == 0)
                  send_random(svc_pkg::OP_ENCODE, rand_value(), 8'($urandom),
                              1'($urandom));
            end
            b = 8'($urandom);
            if ($urandom_range(0, 9) == 0) send_random(svc_pkg::OP_DECODE, $urandom, b, 1'b1);
            else send_random(svc_pkg::OP_DECODE, $urandom, {1'b0, b[6:0]}, 1'b0);
         end else if (sel < 90) begin
            send_random(svc_pkg::OP_DECODE, $urandom, 8'($urandom), 1'b1);
         end else begin
            send_random(svc_pkg::OP_DECODE, $urandom, 8'($urandom), 1'b0);
         end
      end

      // Drain: wait for every owed response, then give the codec time to
      // show anything extra it might still send.
      req_tvalid <= 1'b0;
      while (leb_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d encoded bytes, %0d decoded values,",
               n_requests, n_enc_bytes, n_dec_values);
      $display("%0d stream errors; %0d response transactions checked, %0d mismatches.",
               n_dec_errors, n_checked, n_fail);
      if (n_fail == 0 && leb_results_q.size() == 0) begin
         $display("signed_varint_codec_unit verification clean");
      end else begin
         $display("signed_varint_codec_unit verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response receiver: rsp_tready drops for random bursts while stalls
   // are enabled, and otherwise stays high.
   // ------------------------------------------------------------------------
   initial begin
      int gap;
      rsp_tready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: each accepted transaction is matched against the
   // oldest owed response, field by field.
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      codec_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (leb_results_q.size() == 0) begin
            $error("unexpected response transaction: tdata 0x%0h tuser 0x%0h tlast %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            n_fail++;
         end else begin
            want = leb_results_q.pop_front();
            n_checked++;
            check_field("byte_out",      32'(want.byte_out),    32'(rsp_tdata[7:0]));
            check_field("byte_valid",    32'(want.byte_valid),
                        32'(rsp_tuser[svc_pkg::RSP_USER_BV]));
            check_field("last",          32'(want.last),        32'(rsp_tlast));
            check_field("decoded_value", want.decoded_value,    rsp_tdata[39:8]);
            check_field("value_valid",   32'(want.value_valid),
                        32'(rsp_tuser[svc_pkg::RSP_USER_VV]));
            check_field("error",         32'(want.err),
                        32'(rsp_tuser[svc_pkg::RSP_USER_ERR]));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: ends the run when neither stream has moved a transaction for
   // far longer than the worst mix of sender gaps and receiver stalls.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d responses still owed.", leb_results_q.size());
         $display("signed_varint_codec_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
